// ----- src/mbrtu_pkg.sv -----
// Shared types, constants and the CRC step function for the Modbus RTU slave register server.
package mbrtu_pkg;

	// Sizes of the register stores and the frame buffer.
	localparam int HOLDING_COUNT = 16;
	localparam int INPUT_COUNT   = 8;
	localparam int FRAME_BYTES   = 64;
	localparam int FRAME_AW      = $clog2(FRAME_BYTES);
	localparam int FLEN_W        = $clog2(FRAME_BYTES + 1);
	localparam int REG_DEPTH     = 32;
	localparam int REG_AW        = $clog2(REG_DEPTH);
	localparam int INPUT_REGION  = HOLDING_COUNT;
	localparam int HDR_BYTES     = 7;

	// Reply layout.
	localparam int READ_OVERHEAD    = 5;
	localparam int WRITE_DATA_START = 7;
	localparam int WRITE_REPLY_LEN  = 8;
	localparam int ECHO_BYTES       = 6;

	// Input modes.
	localparam logic [1:0] MODE_BYTE = 2'd0;
	localparam logic [1:0] MODE_END  = 2'd1;
	localparam logic [1:0] MODE_LOAD = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SLAVE   = 2'd0;
	localparam logic [1:0] CFG_HOLDING = 2'd1;
	localparam logic [1:0] CFG_INPUT   = 2'd2;
	localparam logic [1:0] CFG_STATUS  = 2'd3;

	// Function codes.
	localparam logic [7:0] FN_READ_HOLDING = 8'd3;
	localparam logic [7:0] FN_READ_INPUT   = 8'd4;
	localparam logic [7:0] FN_WRITE_SINGLE = 8'd6;
	localparam logic [7:0] FN_WRITE_MULTI  = 8'd16;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  rx_byte;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_last;
		logic       status_written;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_W_HI,
		S_W_LO,
		S_W_PUT,
		S_E_FETCH,
		S_E_LOAD
	} state_t;

	// One byte through the reflected CRC-16.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- src/modbus_rtu_slave_register_server.sv -----
// Modbus RTU slave: collects a frame, checks it, serves register reads and writes.
// Received bytes and input register loads are accepted only while idle; an end-of-frame goes to
// the check state, then S_W_HI, S_W_LO and S_W_PUT per register written by function 16, then
// S_E_FETCH (register store read) and S_E_LOAD (output load) per reply byte, as the stores read registered.
// A new item is accepted once the reply bytes are all loaded; the last may still wait at the output.
// Reset clears the control state, sets the CRC to 0xFFFF and marks all registers as zero.
module modbus_rtu_slave_register_server (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mbrtu_pkg::in_item_t in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mbrtu_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	mbrtu_pkg::state_t state_q, state_d;

	logic [7:0]  slave_q;
	logic [15:0] holding_base_q, input_base_q, status_q;

	logic [mbrtu_pkg::FLEN_W-1:0] len_q;
	logic                         ovf_q;
	logic [15:0]                  crc_q;
	logic [7:0]                   hdr_q [mbrtu_pkg::HDR_BYTES];

	logic       is_read_q, fn4_q, flag_q;
	logic [3:0] off_q;
	logic [4:0] qty_q, i_q;
	logic [5:0] n_q, k_q;
	logic [15:0] rcrc_q;
	logic [7:0]  hi_q;

	logic [mbrtu_pkg::REG_DEPTH-1:0] valid_q;
	logic                            rd_valid_q;

	mbrtu_pkg::out_item_t out_q;
	logic                 out_valid_q;

	logic in_acc, out_free, load_byte;

	// Frame store ports.
	logic                           f_we;
	logic [mbrtu_pkg::FRAME_AW-1:0] f_waddr, f_raddr;
	logic [7:0]                     f_rdata;

	// Register store ports.
	logic                         r_we;
	logic [mbrtu_pkg::REG_AW-1:0] r_waddr, r_raddr;
	logic [15:0]                  r_wdata, r_rdata, r_value;

	mbrtu_ram #(.WIDTH(8), .DEPTH(mbrtu_pkg::FRAME_BYTES)) u_frame (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(in_data.rx_byte),
		.raddr(f_raddr), .rdata(f_rdata)
	);

	mbrtu_ram #(.WIDTH(16), .DEPTH(mbrtu_pkg::REG_DEPTH)) u_regs (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rdata)
	);

	assign in_ready  = (state_q == mbrtu_pkg::S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;
	assign load_byte = (state_q == mbrtu_pkg::S_E_LOAD) && out_free;

	// Frame check decode, from the captured header bytes.
	logic [7:0]  fn, bc;
	logic [15:0] addr, qty, base;
	logic [16:0] off17;
	logic [17:0] sum;
	logic        is_rd, common, below, rd_ok, wr1_ok, wrm_ok;
	logic [5:0]  cnt;
	logic [16:0] stat_end;

	always_comb begin
		fn       = hdr_q[1];
		bc       = hdr_q[6];
		addr     = {hdr_q[2], hdr_q[3]};
		qty      = {hdr_q[4], hdr_q[5]};
		is_rd    = (fn == mbrtu_pkg::FN_READ_HOLDING) || (fn == mbrtu_pkg::FN_READ_INPUT);
		base     = (fn == mbrtu_pkg::FN_READ_INPUT) ? input_base_q : holding_base_q;
		cnt      = (fn == mbrtu_pkg::FN_READ_INPUT) ? 6'(mbrtu_pkg::INPUT_COUNT)
			: 6'(mbrtu_pkg::HOLDING_COUNT);
		off17    = {1'b0, addr} - {1'b0, base};
		below    = off17[16];
		sum      = {2'b00, off17[15:0]} + {2'b00, qty};
		common   = !ovf_q && (len_q >= mbrtu_pkg::FLEN_W'(4)) && (crc_q == 16'h0000)
			&& (hdr_q[0] == slave_q);
		rd_ok    = common && is_rd && (len_q == mbrtu_pkg::FLEN_W'(8)) && !below
			&& (qty != 16'h0000) && (sum <= 18'(cnt));
		wr1_ok   = common && (fn == mbrtu_pkg::FN_WRITE_SINGLE)
			&& (len_q == mbrtu_pkg::FLEN_W'(8)) && !below
			&& (off17[15:0] < 16'(mbrtu_pkg::HOLDING_COUNT));
		wrm_ok   = common && (fn == mbrtu_pkg::FN_WRITE_MULTI)
			&& (len_q >= mbrtu_pkg::FLEN_W'(9))
			&& ({2'b00, len_q} == 9'(9) + {1'b0, bc}) && !below && (qty != 16'h0000)
			&& ({8'h00, bc} == {qty[14:0], 1'b0}) && (qty[15] == 1'b0)
			&& (sum <= 18'(mbrtu_pkg::HOLDING_COUNT));
		stat_end = {1'b0, addr} + {1'b0, qty};
	end

	// Reply byte selection.
	logic [5:0] km3;
	logic [7:0] tx_b;
	logic       is_crc_lo, is_crc_hi;

	assign r_value = r_rdata & {16{rd_valid_q}};

	always_comb begin
		km3       = k_q - 6'd3;
		is_crc_lo = (k_q == n_q - 6'd2);
		is_crc_hi = (k_q == n_q - 6'd1);
		if (is_crc_lo) begin
			tx_b = rcrc_q[7:0];
		end else if (is_crc_hi) begin
			tx_b = rcrc_q[15:8];
		end else if (!is_read_q) begin
			tx_b = hdr_q[k_q[2:0]];
		end else if (k_q == 6'd0) begin
			tx_b = hdr_q[0];
		end else if (k_q == 6'd1) begin
			tx_b = hdr_q[1];
		end else if (k_q == 6'd2) begin
			tx_b = {2'b00, qty_q, 1'b0};
		end else begin
			tx_b = km3[0] ? r_value[7:0] : r_value[15:8];
		end
	end

	// Memory addressing and write enables.
	always_comb begin
		f_we    = in_acc && (in_data.mode == mbrtu_pkg::MODE_BYTE)
			&& (len_q < mbrtu_pkg::FLEN_W'(mbrtu_pkg::FRAME_BYTES));
		f_waddr = len_q[mbrtu_pkg::FRAME_AW-1:0];
		f_raddr = mbrtu_pkg::FRAME_AW'(mbrtu_pkg::WRITE_DATA_START)
			+ mbrtu_pkg::FRAME_AW'({i_q, 1'b0})
			+ mbrtu_pkg::FRAME_AW'(state_q == mbrtu_pkg::S_W_LO);
		r_raddr = mbrtu_pkg::REG_AW'(fn4_q ? mbrtu_pkg::INPUT_REGION : 0)
			+ mbrtu_pkg::REG_AW'(off_q) + mbrtu_pkg::REG_AW'(km3[5:1]);
		r_we    = 1'b0;
		r_waddr = mbrtu_pkg::REG_AW'(off17[3:0]);
		r_wdata = qty;
		if (in_acc && (in_data.mode == mbrtu_pkg::MODE_LOAD)
			&& ({1'b0, in_data.reg_index} < 4'(mbrtu_pkg::INPUT_COUNT))) begin
			r_we    = 1'b1;
			r_waddr = mbrtu_pkg::REG_AW'(mbrtu_pkg::INPUT_REGION)
				+ mbrtu_pkg::REG_AW'(in_data.reg_index);
			r_wdata = in_data.reg_value;
		end else if (state_q == mbrtu_pkg::S_CHECK && wr1_ok) begin
			r_we = 1'b1;
		end else if (state_q == mbrtu_pkg::S_W_PUT) begin
			r_we    = 1'b1;
			r_waddr = mbrtu_pkg::REG_AW'(off_q) + mbrtu_pkg::REG_AW'(i_q);
			r_wdata = {hi_q, f_rdata};
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbrtu_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mbrtu_pkg::S_IDLE: begin
				if (in_acc && in_data.mode == mbrtu_pkg::MODE_END) begin
					state_d = mbrtu_pkg::S_CHECK;
				end
			end
			mbrtu_pkg::S_CHECK: begin
				if (wrm_ok) begin
					state_d = mbrtu_pkg::S_W_HI;
				end else if (rd_ok || wr1_ok) begin
					state_d = mbrtu_pkg::S_E_FETCH;
				end else begin
					state_d = mbrtu_pkg::S_IDLE;
				end
			end
			mbrtu_pkg::S_W_HI: state_d = mbrtu_pkg::S_W_LO;
			mbrtu_pkg::S_W_LO: state_d = mbrtu_pkg::S_W_PUT;
			mbrtu_pkg::S_W_PUT: begin
				state_d = (i_q + 5'd1 == qty_q) ? mbrtu_pkg::S_E_FETCH : mbrtu_pkg::S_W_HI;
			end
			mbrtu_pkg::S_E_FETCH: state_d = mbrtu_pkg::S_E_LOAD;
			mbrtu_pkg::S_E_LOAD: begin
				if (out_free) begin
					state_d = is_crc_hi ? mbrtu_pkg::S_IDLE : mbrtu_pkg::S_E_FETCH;
				end
			end
			default: state_d = mbrtu_pkg::S_IDLE;
		endcase
	end

	// Control state: configuration, frame collection, register valid bits, output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q        <= 8'd1;
			holding_base_q <= 16'h0000;
			input_base_q   <= 16'h0000;
			status_q       <= 16'h0000;
			len_q          <= '0;
			ovf_q          <= 1'b0;
			crc_q          <= mbrtu_pkg::CRC_INIT;
			valid_q        <= '0;
			rd_valid_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mbrtu_pkg::CFG_SLAVE:   slave_q        <= cfg_data[7:0];
					mbrtu_pkg::CFG_HOLDING: holding_base_q <= cfg_data;
					mbrtu_pkg::CFG_INPUT:   input_base_q   <= cfg_data;
					mbrtu_pkg::CFG_STATUS:  status_q       <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc && in_data.mode == mbrtu_pkg::MODE_BYTE) begin
				if (f_we) begin
					len_q <= len_q + mbrtu_pkg::FLEN_W'(1);
					crc_q <= mbrtu_pkg::crc_byte(crc_q, in_data.rx_byte);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == mbrtu_pkg::S_CHECK) begin
				len_q <= '0;
				ovf_q <= 1'b0;
				crc_q <= mbrtu_pkg::CRC_INIT;
			end
			if (r_we) begin
				valid_q[r_waddr] <= 1'b1;
			end
			rd_valid_q <= valid_q[r_raddr];
			if (load_byte) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: header capture, request decode, reply sequencing.
	always_ff @(posedge clk) begin
		if (f_we && len_q < mbrtu_pkg::FLEN_W'(mbrtu_pkg::HDR_BYTES)) begin
			hdr_q[len_q[2:0]] <= in_data.rx_byte;
		end
		case (state_q)
			mbrtu_pkg::S_CHECK: begin
				is_read_q <= is_rd;
				fn4_q     <= (fn == mbrtu_pkg::FN_READ_INPUT);
				off_q     <= off17[3:0];
				qty_q     <= qty[4:0];
				i_q       <= '0;
				k_q       <= '0;
				rcrc_q    <= mbrtu_pkg::CRC_INIT;
				n_q       <= is_rd ? 6'(mbrtu_pkg::READ_OVERHEAD) + {qty[4:0], 1'b0}
					: 6'(mbrtu_pkg::WRITE_REPLY_LEN);
				if (fn == mbrtu_pkg::FN_WRITE_SINGLE) begin
					flag_q <= (addr == status_q);
				end else begin
					flag_q <= !is_rd && (status_q >= addr) && ({1'b0, status_q} < stat_end);
				end
			end
			mbrtu_pkg::S_W_LO: hi_q <= f_rdata;
			mbrtu_pkg::S_W_PUT: begin
				i_q <= i_q + 5'd1;
			end
			default: ;
		endcase
		if (load_byte) begin
			out_q.tx_byte        <= tx_b;
			out_q.tx_last        <= is_crc_hi;
			out_q.status_written <= flag_q;
			k_q                  <= k_q + 6'd1;
			if (!is_crc_lo && !is_crc_hi) begin
				rcrc_q <= mbrtu_pkg::crc_byte(rcrc_q, tx_b);
			end
		end
	end

	// The frame length never passes the buffer size.
	assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= mbrtu_pkg::FLEN_W'(mbrtu_pkg::FRAME_BYTES))
		else $error("frame length beyond buffer");

	// A check cycle only follows an accepted end-of-frame transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mbrtu_pkg::S_CHECK) |-> $past(in_acc && in_data.mode == mbrtu_pkg::MODE_END))
		else $error("frame check without end of frame");

	// Multi-register writes stay inside the holding registers.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mbrtu_pkg::S_W_PUT)
		|-> (({1'b0, off_q} + i_q) < 5'(mbrtu_pkg::HOLDING_COUNT)))
		else $error("holding register write out of range");

endmodule

// ----- src/mbrtu_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module mbrtu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- tb/sv/modbus_rtu_slave_register_server_tb.sv -----
// Testbench for the Modbus RTU slave register server: directed and random frames checked per reply byte.
module modbus_rtu_slave_register_server_tb;
	import mbrtu_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_SLAVE;
	logic [15:0] cfg_data = '0;

	// Predictor state.
	logic [7:0] own_addr;
	logic [15:0] hold_base, inp_base, stat_addr;
	logic [7:0] rx_frame [FRAME_BYTES];
	int rx_len;
	bit rx_over;
	logic [15:0] rx_crc;
	logic [15:0] hold_regs [HOLDING_COUNT];
	logic [15:0] inp_regs [INPUT_COUNT];

	out_item_t reply_queue [$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit timed_out = 1'b0;

	modbus_rtu_slave_register_server i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Gap length: mostly short, sometimes long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
		c = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [15:0] frame_word(int p);
		return {rx_frame[p], rx_frame[p + 1]};
	endfunction

	// Queue a reply with its CRC appended low byte first.
	task automatic push_reply(logic [7:0] bytes [$], bit flag);
		logic [15:0] c;
		out_item_t o;
		c = 16'hFFFF;
		foreach (bytes[i]) begin
			c = crc_step(c, bytes[i]);
		end
		bytes.push_back(c[7:0]);
		bytes.push_back(c[15:8]);
		foreach (bytes[i]) begin
			o.tx_byte = bytes[i];
			o.tx_last = (i == bytes.size() - 1);
			o.status_written = flag;
			reply_queue.push_back(o);
		end
	endtask

	// Serve a finished frame; returns without a reply on any failed check.
	task automatic serve_frame();
		logic [7:0] bytes [$];
		logic [7:0] fn;
		int addr, qty, off, bc, base, cnt;
		logic [15:0] v;
		if (rx_over || rx_len < 4 || rx_crc != 16'h0000 || rx_frame[0] != own_addr) begin
			return;
		end
		fn = rx_frame[1];
		addr = frame_word(2);
		qty = frame_word(4);
		if (fn == FN_READ_HOLDING || fn == FN_READ_INPUT) begin
			base = (fn == FN_READ_HOLDING) ? hold_base : inp_base;
			cnt = (fn == FN_READ_HOLDING) ? HOLDING_COUNT : INPUT_COUNT;
			if (rx_len != 8 || addr < base || qty == 0 || addr - base + qty > cnt) begin
				return;
			end
			off = addr - base;
			bytes = '{rx_frame[0], fn, 8'(qty * 2)};
			for (int i = 0; i < qty; i++) begin
				v = (fn == FN_READ_HOLDING) ? hold_regs[off + i] : inp_regs[off + i];
				bytes.push_back(v[15:8]);
				bytes.push_back(v[7:0]);
			end
			push_reply(bytes, 1'b0);
		end else if (fn == FN_WRITE_SINGLE) begin
			if (rx_len != 8 || addr < hold_base || addr - hold_base >= HOLDING_COUNT) begin
				return;
			end
			hold_regs[addr - hold_base] = frame_word(4);
			for (int i = 0; i < 6; i++) begin
				bytes.push_back(rx_frame[i]);
			end
			push_reply(bytes, addr == stat_addr);
		end else if (fn == FN_WRITE_MULTI) begin
			if (rx_len < 9) begin
				return;
			end
			bc = rx_frame[6];
			if (rx_len != 9 + bc || addr < hold_base || qty == 0 || bc != qty * 2
					|| addr - hold_base + qty > HOLDING_COUNT) begin
				return;
			end
			off = addr - hold_base;
			for (int i = 0; i < qty; i++) begin
				hold_regs[off + i] = frame_word(WRITE_DATA_START + 2 * i);
			end
			for (int i = 0; i < 6; i++) begin
				bytes.push_back(rx_frame[i]);
			end
			push_reply(bytes, stat_addr >= addr && stat_addr < addr + qty);
		end
	endtask

	// Predict the effect of one accepted input item.
	task automatic predict_item(in_item_t it);
		case (it.mode)
			MODE_BYTE: begin
				if (rx_len < FRAME_BYTES) begin
					rx_frame[rx_len] = it.rx_byte;
					rx_len++;
					rx_crc = crc_step(rx_crc, it.rx_byte);
				end else begin
					rx_over = 1'b1;
				end
			end
			MODE_END: begin
				serve_frame();
				rx_len = 0;
				rx_over = 1'b0;
				rx_crc = 16'hFFFF;
			end
			MODE_LOAD: begin
				if (it.reg_index < INPUT_COUNT) begin
					inp_regs[it.reg_index] = it.reg_value;
				end
			end
			default: begin
			end
		endcase
	endtask

	// Send one item, holding valid until accepted; valid drops only for a gap or a drain.
	task automatic send_item(in_item_t it);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_item(it);
	endtask

	task automatic send_byte(logic [7:0] b);
		in_item_t it;
		it = '0;
		it.mode = MODE_BYTE;
		it.rx_byte = b;
		it.reg_index = 3'($urandom);
		it.reg_value = 16'($urandom);
		send_item(it);
	endtask

	task automatic send_end();
		in_item_t it;
		it = in_item_t'($urandom);
		it.mode = MODE_END;
		send_item(it);
	endtask

	// Send a frame body with a correct CRC (or a broken one), then end of frame.
	task automatic send_frame(logic [7:0] body [$], bit bad_crc = 1'b0);
		logic [15:0] c;
		c = 16'hFFFF;
		foreach (body[i]) begin
			c = crc_step(c, body[i]);
		end
		if (bad_crc) begin
			c = c ^ 16'(1 << $urandom_range(0, 15));
		end
		body.push_back(c[7:0]);
		body.push_back(c[15:8]);
		foreach (body[i]) begin
			send_byte(body[i]);
		end
		send_end();
	endtask

	task automatic send_load(logic [2:0] idx, logic [15:0] val);
		in_item_t it;
		it = '0;
		it.mode = MODE_LOAD;
		it.rx_byte = 8'($urandom);
		it.reg_index = idx;
		it.reg_value = val;
		send_item(it);
	endtask

	// Wait until every expected reply byte has come and the block is settled.
	task automatic drain();
		in_valid <= 1'b0;
		while (reply_queue.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// One register write; valid stays high for a following write.
	task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_SLAVE: own_addr = val[7:0];
			CFG_HOLDING: hold_base = val;
			CFG_INPUT: inp_base = val;
			default: stat_addr = val;
		endcase
	endtask

	task automatic set_config(logic [7:0] sa, logic [15:0] hb, logic [15:0] ib, logic [15:0] st);
		drain();
		write_cfg(CFG_SLAVE, {8'h00, sa});
		write_cfg(CFG_HOLDING, hb);
		write_cfg(CFG_INPUT, ib);
		write_cfg(CFG_STATUS, st);
		cfg_valid <= 1'b0;
	endtask

	function automatic void hdr(ref logic [7:0] b [$], input logic [7:0] a, input logic [7:0] fn,
			input logic [15:0] w1, input logic [15:0] w2);
		b = '{a, fn, w1[15:8], w1[7:0], w2[15:8], w2[7:0]};
	endfunction

	// Directed cases: every function, range limits and several dropped-frame cases.
	task automatic test_directed();
		logic [7:0] b [$];
		send_load(3'd0, 16'hFFFF);
		send_load(3'd7, 16'h0000);
		send_load(3'd5, 16'hA55A);
		hdr(b, own_addr, FN_WRITE_SINGLE, hold_base, 16'hFFFF); send_frame(b);
		hdr(b, own_addr, FN_WRITE_SINGLE, hold_base + 16'd15, 16'h1234); send_frame(b);
		hdr(b, own_addr, FN_READ_HOLDING, hold_base, 16'd16); send_frame(b);
		hdr(b, own_addr, FN_READ_INPUT, inp_base, 16'd8); send_frame(b);
		hdr(b, own_addr, FN_READ_INPUT, inp_base + 16'd7, 16'd1); send_frame(b);
		hdr(b, own_addr, FN_READ_HOLDING, hold_base, 16'd17); send_frame(b);
		hdr(b, own_addr, FN_READ_HOLDING, hold_base, 16'd0); send_frame(b);
		hdr(b, own_addr, FN_WRITE_SINGLE, hold_base + 16'd16, 16'd1); send_frame(b);
		hdr(b, own_addr, FN_WRITE_MULTI, hold_base + 16'd14, 16'd2);
		b.push_back(8'd4);
		repeat (4) b.push_back(8'($urandom));
		send_frame(b);
		hdr(b, own_addr, FN_READ_HOLDING, hold_base, 16'd2); send_frame(b, 1'b1);
		hdr(b, 8'd0, FN_WRITE_SINGLE, hold_base, 16'd2); send_frame(b);
		hdr(b, own_addr + 8'd1, FN_READ_HOLDING, hold_base, 16'd2); send_frame(b);
		hdr(b, own_addr, 8'd1, hold_base, 16'd2); send_frame(b);
		b = '{own_addr}; send_frame(b);
		send_end();
	endtask

	// Mode 3 items do nothing.
	task automatic test_ignored();
		in_item_t it;
		for (int i = 0; i < 4; i++) begin
			it = in_item_t'($urandom);
			it.mode = 2'd3;
			send_item(it);
		end
	endtask

	// A frame longer than the buffer is dropped.
	task automatic test_overflow();
		logic [7:0] b [$];
		hdr(b, own_addr, FN_READ_HOLDING, hold_base, 16'd1);
		repeat (FRAME_BYTES) b.push_back(8'($urandom));
		send_frame(b);
		hdr(b, own_addr, FN_READ_HOLDING, hold_base, 16'd1); send_frame(b);
	endtask

	// Random frames: mostly well formed, some broken, plus loads and noise.
	task automatic test_random(int n_frames);
		logic [7:0] b [$];
		int kind, off, qty;
		logic [7:0] fn;
		for (int f = 0; f < n_frames; f++) begin
			kind = $urandom_range(0, 99);
			if (kind < 15) begin
				send_load(3'($urandom), 16'($urandom));
				continue;
			end
			if (kind < 22) begin
				b = {};
				repeat ($urandom_range(0, 12)) b.push_back(8'($urandom));
				foreach (b[i]) send_byte(b[i]);
				send_end();
				continue;
			end
			case ($urandom_range(0, 3))
				0: fn = FN_READ_HOLDING;
				1: fn = FN_READ_INPUT;
				2: fn = FN_WRITE_SINGLE;
				default: fn = FN_WRITE_MULTI;
			endcase
			off = $urandom_range(0, (fn == FN_READ_INPUT) ? 7 : 15);
			qty = $urandom_range(1, ((fn == FN_READ_INPUT) ? 8 : 16) - off);
			if ($urandom_range(0, 9) == 0) begin
				off = off + int'($urandom_range(0, 6)) - 2;
			end
			hdr(b, (kind < 90) ? own_addr : 8'($urandom), fn,
				16'(((fn == FN_READ_INPUT) ? inp_base : hold_base) + off),
				(fn == FN_WRITE_SINGLE) ? 16'($urandom) : 16'(qty));
			if (fn == FN_WRITE_MULTI) begin
				b.push_back(8'(qty * 2));
				repeat (qty * 2) b.push_back(8'($urandom));
			end
			send_frame(b, kind >= 95);
		end
	endtask

	// Hold-off until all replies are out, then continue.
	task automatic test_pause();
		logic [7:0] b [$];
		drain();
		hdr(b, own_addr, FN_READ_HOLDING, hold_base, 16'd4); send_frame(b);
	endtask

	// Output side: random stalls, checking against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			out_ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (reply_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected reply byte %h last %b status %b",
						out_data.tx_byte, out_data.tx_last, out_data.status_written);
				end
			end else begin
				if (out_data !== reply_queue[0]) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("reply mismatch: expected byte %h last %b status %b, got %h %b %b",
							reply_queue[0].tx_byte, reply_queue[0].tx_last,
							reply_queue[0].status_written, out_data.tx_byte,
							out_data.tx_last, out_data.status_written);
					end
				end
				void'(reply_queue.pop_front());
			end
		end
	end

	// Watchdog on cycles without any accepted transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("** modbus_rtu_slave_register_server: FAILED **");
			$finish;
		end
	end

	initial begin
		own_addr = 8'd1;
		hold_base = '0;
		inp_base = '0;
		stat_addr = '0;
		rx_len = 0;
		rx_over = 1'b0;
		rx_crc = 16'hFFFF;
		foreach (hold_regs[i]) hold_regs[i] = '0;
		foreach (inp_regs[i]) inp_regs[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ignored();
		set_config(8'd247, 16'hFFF0, 16'hFFF8, 16'hFFFF);
		test_directed();
		test_overflow();
		set_config(8'd1, 16'd0, 16'd0, 16'd3);
		test_random(4);
		test_pause();
		set_config(8'($urandom_range(1, 247)), 16'($urandom_range(0, 200)),
			16'($urandom_range(0, 65527)), 16'($urandom_range(0, 210)));
		test_random(4);
		set_config(8'd17, 16'd40000, 16'd100, 16'd40005);
		test_random(4);

		drain();
		if (mismatches == 0) begin
			$display("** modbus_rtu_slave_register_server: PASSED **");
		end else begin
			$display("** modbus_rtu_slave_register_server: FAILED **");
		end
		$finish;
	end

endmodule
